// ----- design/assert_macros.svh -----
// assertion macros used by b2d_emitter
// no dependencies; expects clk and rst_n in the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define B2D_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define B2D_ASSERT_NEXT(label, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define B2D_ASSERT(label, prop)
`define B2D_ASSERT_NEXT(label, cond, prop)
`endif
`endif

// ----- design/b2d_pkg.sv -----
// types and constants for the binary to decimal ascii converter
// no dependencies
package b2d_pkg;
    localparam int VALUE_W    = 31;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CHAR_W     = 6;
    localparam int IDX_W      = 4;
    localparam logic [1:0] ASCII_ZERO_HI = 2'b11;

    typedef struct packed {
        logic [BCD_W-1:0]   bcd;
        logic [VALUE_W-1:0] bin;
    } dab_t;
endpackage

// ----- design/b2d_dabble_stage.sv -----
// one pipeline stage of the shift-add-3 conversion, STEPS input bits per stage
// depends on b2d_pkg
module b2d_dabble_stage #(
    parameter int STEPS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  b2d_pkg::dab_t in_data,
    output logic          out_valid,
    input  logic          out_ready,
    output b2d_pkg::dab_t out_data
);
    import b2d_pkg::*;

    logic valid_reg;
    dab_t data_reg;
    dab_t data_next;

    always_comb
    begin
        logic [BCD_W+VALUE_W-1:0] acc;
        acc = in_data;
        for (int s = 0; s < STEPS; s++)
        begin
            for (int d = 0; d < NUM_DIGITS; d++)
            begin
                if (acc[VALUE_W+4*d +: 4] >= 4'd5)
                begin
                    acc[VALUE_W+4*d +: 4] = acc[VALUE_W+4*d +: 4] + 4'd3;
                end
            end
            acc = {acc[BCD_W+VALUE_W-2:0], 1'b0};
        end
        data_next = acc;
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end
endmodule

// ----- design/b2d_emitter.sv -----
// digit emitter: counts significant digits (at most MAX_DIGITS) and sends them msd first
// depends on b2d_pkg and assert_macros.svh
`include "assert_macros.svh"
module b2d_emitter #(
    parameter int MAX_DIGITS = 10
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [b2d_pkg::BCD_W-1:0]  in_bcd,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [b2d_pkg::CHAR_W-1:0] out_char,
    output logic                       out_last
);
    import b2d_pkg::*;

    localparam int CAP = (MAX_DIGITS < NUM_DIGITS) ? MAX_DIGITS : NUM_DIGITS;

    logic             busy_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [BCD_W-1:0] bcd_reg;
    logic [3:0]       digit;

    always_comb
    begin
        logic [IDX_W-1:0] n;
        n = IDX_W'(1);
        for (int d = 0; d < NUM_DIGITS; d++)
        begin
            if (in_bcd[4*d +: 4] != 4'd0)
            begin
                n = IDX_W'(d + 1);
            end
        end
        if (n > IDX_W'(CAP))
        begin
            n = IDX_W'(CAP);
        end
        idx_next = n - IDX_W'(1);
    end

    assign digit     = bcd_reg[{idx_reg, 2'b00} +: 4];
    assign out_char  = {ASCII_ZERO_HI, digit};
    assign out_last  = (idx_reg == '0);
    assign out_valid = busy_reg;
    assign in_ready  = !busy_reg || (out_ready && out_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (in_ready)
        begin
            busy_reg <= in_valid;
            idx_reg  <= in_valid ? idx_next : '0;
        end
        else if (out_ready)
        begin
            idx_reg <= idx_reg - IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            bcd_reg <= in_bcd;
        end
    end

    `B2D_ASSERT(a_idx_range, busy_reg |-> (idx_reg < IDX_W'(CAP)))
    `B2D_ASSERT(a_char_digit, busy_reg |-> (digit <= 4'd9))
    `B2D_ASSERT_NEXT(a_run_continues, busy_reg && out_ready && !out_last,
        busy_reg && (idx_reg == $past(idx_reg) - IDX_W'(1)))
endmodule

// ----- design/binary_to_decimal_ascii.sv -----
// Converts a 31-bit unsigned integer to its decimal ASCII digits, most
// significant first, no leading zeros (zero gives one '0'), tlast on the final
// digit. Four shift-add-3 stages sit before the emitter; each stage and the
// emitter register a value before its first digit is offered. A new value can
// enter each cycle while the emitter does not hold the stages. The single
// digit emitter sends 1 to min(MAX_DIGITS, 10) characters per value, one per cycle
// while m_tready is high. Depends on b2d_pkg, b2d_dabble_stage and b2d_emitter.
module binary_to_decimal_ascii #(
    parameter int MAX_DIGITS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [30:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] character
    output logic        m_tlast
);
    import b2d_pkg::*;

    logic [4:0] v;
    logic [4:0] r;
    dab_t       d [5];
    logic [CHAR_W-1:0] ch;

    assign v[0]     = s_tvalid;
    assign s_tready = r[0];
    assign d[0]     = {{BCD_W{1'b0}}, s_tdata[VALUE_W-1:0]};

    b2d_dabble_stage #(.STEPS(8)) u_st0 (.clk, .rst_n, .in_valid(v[0]), .in_ready(r[0]),
        .in_data(d[0]), .out_valid(v[1]), .out_ready(r[1]), .out_data(d[1]));
    b2d_dabble_stage #(.STEPS(8)) u_st1 (.clk, .rst_n, .in_valid(v[1]), .in_ready(r[1]),
        .in_data(d[1]), .out_valid(v[2]), .out_ready(r[2]), .out_data(d[2]));
    b2d_dabble_stage #(.STEPS(8)) u_st2 (.clk, .rst_n, .in_valid(v[2]), .in_ready(r[2]),
        .in_data(d[2]), .out_valid(v[3]), .out_ready(r[3]), .out_data(d[3]));
    b2d_dabble_stage #(.STEPS(7)) u_st3 (.clk, .rst_n, .in_valid(v[3]), .in_ready(r[3]),
        .in_data(d[3]), .out_valid(v[4]), .out_ready(r[4]), .out_data(d[4]));

    b2d_emitter #(.MAX_DIGITS(MAX_DIGITS)) u_emit (
        .clk, .rst_n,
        .in_valid(v[4]), .in_ready(r[4]), .in_bcd(d[4].bcd),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_char(ch), .out_last(m_tlast)
    );

    assign m_tdata = {2'b00, ch};
endmodule
